### hdl/pbl_pkg.sv
// ----------------------------------------------------------------------------
// pbl_pkg: shared types and constants of the positional byte list
// sizes, operation codes and the control word broadcast to the cell row
// ----------------------------------------------------------------------------
package pbl_pkg;

	localparam int CAPACITY = 32;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int DATA_W   = 8;
	localparam int POS_W    = 8;
	localparam int MODE_W   = 2;
	localparam int LEN_W    = 6;

	typedef enum logic [MODE_W-1:0] {
		MODE_INSERT = 2'd0,
		MODE_DELETE = 2'd1,
		MODE_READ   = 2'd2,
		MODE_NONE   = 2'd3
	} pbl_mode_t;

	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_INSERT = 2'd1,
		CELL_DELETE = 2'd2
	} pbl_cell_op_t;

	// control word seen by every cell in the row
	typedef struct packed {
		pbl_cell_op_t      op;
		logic [IDX_W-1:0]  idx;
		logic [DATA_W-1:0] value;
	} pbl_cell_ctl_t;

endpackage

### hdl/pbl_cmd_if.sv
// ----------------------------------------------------------------------------
// pbl_cmd_if: command channel of the positional byte list
// valid/ready handshake carrying mode, position and value
// ----------------------------------------------------------------------------
interface pbl_cmd_if
	import pbl_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mode;
	logic [POS_W-1:0]  position;
	logic [DATA_W-1:0] value;

	modport source (output valid, output mode, output position, output value, input ready);
	modport sink   (input valid, input mode, input position, input value, output ready);
endinterface

### hdl/pbl_rsp_if.sv
// ----------------------------------------------------------------------------
// pbl_rsp_if: response channel of the positional byte list
// valid/ready handshake carrying read_value, done_res and length
// ----------------------------------------------------------------------------
interface pbl_rsp_if
	import pbl_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] read_value;
	logic              done_res;
	logic [LEN_W-1:0]  length;

	modport source (output valid, output read_value, output done_res, output length,
		input ready);
	modport sink   (input valid, input read_value, input done_res, input length,
		output ready);
endinterface

### hdl/pbl_cell.sv
// ----------------------------------------------------------------------------
// pbl_cell: one storage cell of the list row
// holds one byte; shifts right on insert, left on delete, or loads the new byte
// ----------------------------------------------------------------------------
module pbl_cell
	import pbl_pkg::*;
(
	input  logic              clk,
	input  pbl_cell_ctl_t     ctl,
	input  logic [IDX_W-1:0]  cell_idx,
	input  logic [DATA_W-1:0] left,
	input  logic [DATA_W-1:0] right,
	output logic [DATA_W-1:0] data
);

	logic [DATA_W-1:0] data_q;
	logic [DATA_W-1:0] data_d;

	always_comb begin
		data_d = data_q;
		case (ctl.op)
			CELL_INSERT: begin
				if (cell_idx > ctl.idx) begin
					data_d = left;
				end else if (cell_idx == ctl.idx) begin
					data_d = ctl.value;
				end
			end
			CELL_DELETE: begin
				if (cell_idx >= ctl.idx) begin
					data_d = right;
				end
			end
			default: begin
				data_d = data_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data = data_q;

endmodule

### hdl/positional_byte_list.sv
// ----------------------------------------------------------------------------
// positional_byte_list: ordered list of bytes with positional insert/delete/read
// top level: command decode, entry count, cell row and response register
// ----------------------------------------------------------------------------
// The list lives in a row of CAPACITY byte cells; cell 0 is the front. On
// the accepting edge of a command item the whole row shifts right behind
// the insert point (or left over the deleted entry), the entry count updates
// and the response item is loaded into the output register. One item per
// cycle is sustained while the response side takes items; the command side
// stalls only while a response waits unaccepted. Positions are 1-based. An
// insert at position 0 or 1 goes to the front, any position past the end
// appends, and an insert into a full list is refused with done_res low. A
// delete or read outside 1..length changes nothing and returns done_res low;
// read_value is zero unless a read hits. Mode 3 is a no-op. length reports
// the entry count after the operation (low six bits). Cells beyond the count
// hold stale bytes and are never returned. There is no fill or clear phase
// after reset: the list starts empty.
// ----------------------------------------------------------------------------
module positional_byte_list
	import pbl_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	pbl_cmd_if.sink    cmd,
	pbl_rsp_if.source  rsp
);

	// entry count and response register
	logic [CNT_W-1:0]  count_q;
	logic              rsp_valid_q;
	logic [DATA_W-1:0] rsp_read_value_q;
	logic              rsp_done_q;
	logic [LEN_W-1:0]  rsp_length_q;

	// command decode
	logic              cmd_fire;
	logic [POS_W:0]    pos_ext;
	logic [POS_W:0]    cnt_ext;
	logic [POS_W:0]    ins_at;
	logic              full;
	logic              in_range;
	logic              ins_ok;
	logic              del_ok;
	logic              rd_hit;
	logic [IDX_W-1:0]  pos_idx;
	logic [CNT_W-1:0]  count_d;
	logic [DATA_W-1:0] rd_data;
	pbl_cell_ctl_t     cell_ctl;

	logic [DATA_W-1:0] cell_data [CAPACITY];

	// a response slot frees up when the waiting item is taken
	assign cmd.ready = !rsp_valid_q || rsp.ready;
	assign cmd_fire  = cmd.valid && cmd.ready;

	assign pos_ext  = {1'b0, cmd.position};
	assign cnt_ext  = (POS_W+1)'(count_q);
	assign full     = (count_q == CNT_W'(CAPACITY));
	assign in_range = (pos_ext >= (POS_W+1)'(1)) && (pos_ext <= cnt_ext);
	assign pos_idx  = IDX_W'(pos_ext - (POS_W+1)'(1));

	// insert point: front for position 0/1, end when past the tail
	always_comb begin
		if (pos_ext <= (POS_W+1)'(1)) begin
			ins_at = '0;
		end else if (pos_ext - (POS_W+1)'(1) > cnt_ext) begin
			ins_at = cnt_ext;
		end else begin
			ins_at = pos_ext - (POS_W+1)'(1);
		end
	end

	assign ins_ok = cmd_fire && (pbl_mode_t'(cmd.mode) == MODE_INSERT) && !full;
	assign del_ok = cmd_fire && (pbl_mode_t'(cmd.mode) == MODE_DELETE) && in_range;
	assign rd_hit = (pbl_mode_t'(cmd.mode) == MODE_READ) && in_range;

	// broadcast control to the cell row
	always_comb begin
		cell_ctl.value = cmd.value;
		cell_ctl.idx   = pos_idx;
		cell_ctl.op    = CELL_HOLD;
		if (ins_ok) begin
			cell_ctl.op  = CELL_INSERT;
			cell_ctl.idx = IDX_W'(ins_at);
		end else if (del_ok) begin
			cell_ctl.op  = CELL_DELETE;
		end
	end

	// row of cells; each cell sees its neighbors (zero left of cell 0, itself right of the last)
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_W-1:0] left_data;
		logic [DATA_W-1:0] right_data;

		if (i == 0) begin : g_first
			assign left_data = '0;
		end else begin : g_mid_l
			assign left_data = cell_data[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_data = cell_data[i];
		end else begin : g_mid_r
			assign right_data = cell_data[i+1];
		end

		pbl_cell u_cell (
			.clk      (clk),
			.ctl      (cell_ctl),
			.cell_idx (IDX_W'(i)),
			.left     (left_data),
			.right    (right_data),
			.data     (cell_data[i])
		);
	end

	// read select, only looked at when the position is in range
	assign rd_data = rd_hit ? cell_data[pos_idx] : '0;

	// entry count after this item
	always_comb begin
		count_d = count_q;
		if (ins_ok) begin
			count_d = count_q + CNT_W'(1);
		end else if (del_ok) begin
			count_d = count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (cmd_fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// response payload, loaded with each accepted item
	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			rsp_read_value_q <= rd_data;
			rsp_done_q       <= ins_ok || del_ok || rd_hit;
			rsp_length_q     <= LEN_W'(count_d);
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.read_value = rsp_read_value_q;
	assign rsp.done_res   = rsp_done_q;
	assign rsp.length     = rsp_length_q;

	// count stays within the row
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	// a successful insert grows the list by one
	a_ins_count: assert property (@(posedge clk) disable iff (!arst_n)
		ins_ok |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("insert did not grow the list");

	// a successful delete shrinks the list by one
	a_del_count: assert property (@(posedge clk) disable iff (!arst_n)
		del_ok |=> count_q == $past(count_q) - CNT_W'(1))
		else $error("delete did not shrink the list");

	// a new item never overwrites a response still waiting
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_fire |-> (!rsp_valid_q || rsp.ready))
		else $error("response overwritten before taken");

	// the reported length matches the count after the item
	a_len_match: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_fire |=> rsp_length_q == LEN_W'(count_q))
		else $error("reported length differs from count");

endmodule
